// ----- rtl/swcrc_pkg.sv -----
`default_nettype none

package swcrc_pkg;

  // field and register widths
  localparam int WIN_W     = 18;
  localparam int TIME_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int INDEX_W   = 4;
  localparam int CHAN_W    = 4;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 56;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MASK    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN = 1'b1;

  // register reset values
  localparam logic [WIN_W-1:0] SYNC_MASK_RESET    = 18'h3FEFF;
  localparam logic [WIN_W-1:0] SYNC_PATTERN_RESET = 18'h3FAFD;

  // two implied ones above the window that complete byte 0
  localparam logic [1:0] FIX_BITS = 2'b11;

  localparam logic [7:0] CRC_POLY = 8'h31;

  // frame status codes
  localparam logic [STATUS_W-1:0] STAT_CRC_ERR  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_GOOD     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_VERIFIED = 2'd2;

  // per-frame result fields shared by every byte of the frame
  typedef struct packed {
    logic [TIME_W-1:0]   gap;
    logic [CHAN_W-1:0]   channel;
    logic [STATUS_W-1:0] status;
  } frame_info_t;

  // crc-8 over one byte, msb first, no reflection
  function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/swcrc_deframer.sv -----
`default_nettype none

module swcrc_deframer #(
  parameter int FRAME_BYTES = 11
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [swcrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [swcrc_pkg::WIN_W-1:0]          cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 rx_bit,
  input  wire logic [swcrc_pkg::TIME_W-1:0]         time_ms,
  input  wire logic                                 out_busy,
  output logic                                      load,
  output logic [swcrc_pkg::BYTE_W-1:0]              frame_bytes [FRAME_BYTES],
  output swcrc_pkg::frame_info_t                    frame_info
);
  import swcrc_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  logic [WIN_W-1:0]  sync_mask;
  logic [WIN_W-1:0]  sync_pattern;
  logic [WIN_W-1:0]  sync_window;
  logic              hunting;
  logic [IDX_W-1:0]  byte_count;
  logic [2:0]        bit_count;
  logic [7:0]        crc_reg;
  logic [BYTE_W-1:0] frame_store [FRAME_BYTES];
  logic              have_previous;
  logic [CHAN_W-1:0] previous_channel;
  logic [BYTE_W-1:0] previous_last_byte;
  logic [TIME_W-1:0] last_verified_time;

  logic              accept;
  logic [WIN_W-1:0]  window_shift;
  logic              sync_hit;
  logic [BYTE_W-1:0] byte_shift;
  logic              byte_done;
  logic              frame_end;
  logic [7:0]        crc_next;
  logic [CHAN_W-1:0] chan;
  logic              repeat_match;
  logic [STATUS_W-1:0] status;

  // stall only on the bit that would complete a frame while one is still going out
  assign in_ready  = !(!hunting && byte_count == LAST_IDX && bit_count == 3'd7 && out_busy);
  assign accept    = in_valid && in_ready;

  // sync search
  assign window_shift = {sync_window[WIN_W-2:0], rx_bit};
  assign sync_hit     = (window_shift & sync_mask) == sync_pattern;

  // byte collection and crc
  assign byte_shift = {frame_store[byte_count][BYTE_W-2:0], rx_bit};
  assign byte_done  = bit_count == 3'd7;
  assign frame_end  = byte_done && byte_count == LAST_IDX;
  assign crc_next   = crc_byte(crc_reg, byte_shift);

  // frame verdict
  assign chan         = frame_store[1][BYTE_W-1:BYTE_W-CHAN_W];
  assign repeat_match = have_previous && chan == previous_channel
                        && byte_shift == previous_last_byte;

  always_comb begin
    if (crc_next != 8'h00) begin
      status = STAT_CRC_ERR;
    end else if (repeat_match) begin
      status = STAT_VERIFIED;
    end else begin
      status = STAT_GOOD;
    end
  end

  assign load               = accept && !hunting && frame_end;
  assign frame_info.status  = status;
  assign frame_info.channel = chan;
  assign frame_info.gap     = (status == STAT_VERIFIED) ? time_ms - last_verified_time
                                                        : '0;

  // completed frame with the final byte merged in
  always_comb begin
    for (int k = 0; k < FRAME_BYTES; k++) begin
      frame_bytes[k] = (IDX_W'(k) == byte_count) ? byte_shift : frame_store[k];
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_mask          <= SYNC_MASK_RESET;
      sync_pattern       <= SYNC_PATTERN_RESET;
      sync_window        <= '0;
      hunting            <= 1'b1;
      byte_count         <= '0;
      bit_count          <= '0;
      crc_reg            <= '0;
      have_previous      <= 1'b0;
      previous_channel   <= '0;
      previous_last_byte <= '0;
      last_verified_time <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SYNC_MASK:    sync_mask    <= cfg_data;
          REG_SYNC_PATTERN: sync_pattern <= cfg_data;
        endcase
      end
      if (accept) begin
        if (hunting) begin
          if (sync_hit) begin
            sync_window <= '0;
            hunting     <= 1'b0;
            byte_count  <= IDX_W'(2);
            bit_count   <= 3'd4;
            crc_reg     <= crc_byte(8'h00, window_shift[11:4]);
          end else begin
            sync_window <= window_shift;
          end
        end else begin
          bit_count <= bit_count + 3'd1;
          if (byte_done) begin
            crc_reg <= crc_next;
            if (frame_end) begin
              byte_count <= '0;
            end else begin
              byte_count <= byte_count + IDX_W'(1);
            end
          end
          if (frame_end) begin
            hunting     <= 1'b1;
            sync_window <= '0;
            if (status == STAT_CRC_ERR) begin
              have_previous <= 1'b0;
            end else begin
              previous_channel   <= chan;
              previous_last_byte <= byte_shift;
              if (status == STAT_VERIFIED) begin
                last_verified_time <= time_ms;
                have_previous      <= 1'b0;
              end else begin
                have_previous <= 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // frame byte store
  always_ff @(posedge clk) begin
    if (accept) begin
      if (hunting) begin
        if (sync_hit) begin
          frame_store[0] <= {FIX_BITS, window_shift[17:12]};
          frame_store[1] <= window_shift[11:4];
          frame_store[2] <= {4'h0, window_shift[3:0]};
        end
      end else begin
        frame_store[byte_count] <= byte_shift;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/swcrc_emitter.sv -----
`default_nettype none

module swcrc_emitter #(
  parameter int FRAME_BYTES = 11
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             load,
  input  wire logic [swcrc_pkg::BYTE_W-1:0]     frame_bytes [FRAME_BYTES],
  input  wire swcrc_pkg::frame_info_t           frame_info,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [swcrc_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                  m_tlast
);
  import swcrc_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  logic              busy;
  logic [IDX_W-1:0]  cnt;
  logic [BYTE_W-1:0] snap [FRAME_BYTES];
  frame_info_t       info;

  assign m_tvalid = busy;
  assign m_tlast  = cnt == LAST_IDX;
  assign m_tdata  = {6'b0, info.gap, info.channel, info.status, INDEX_W'(cnt), snap[cnt]};

  // byte sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && m_tready) begin
      if (m_tlast) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + IDX_W'(1);
      end
    end
  end

  // frame snapshot
  always_ff @(posedge clk) begin
    if (load) begin
      snap <= frame_bytes;
      info <= frame_info;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sync_word_crc8_frame_receiver.sv -----
// output: the first byte request of a frame is valid in the cycle after the bit
//   completing it is taken; bytes then go out one per cycle while m_tready is high
// throughput: one bit per cycle; the completing bit of a frame stalls only while
//   the previous frame's bytes are still being sent from the output snapshot
// reset: synchronous, clears the search and verify state and reloads the sync
//   mask and pattern defaults; there is no clearing pass
`default_nettype none

module sync_word_crc8_frame_receiver #(
  parameter int FRAME_BYTES = 11
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [swcrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [swcrc_pkg::WIN_W-1:0]        cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // rx_bit [0], time_ms [32:1], zero fill
  input  wire logic [swcrc_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // frame_byte [7:0], byte_index [11:8], frame_status [13:12],
  // channel_code [17:14], verified_gap_ms [49:18], zero fill
  output logic [swcrc_pkg::M_TDATA_W-1:0]         m_tdata,
  output logic                                    m_tlast
);
  import swcrc_pkg::*;

  logic        load;
  logic [BYTE_W-1:0] frame_bytes [FRAME_BYTES];
  frame_info_t frame_info;

  // sync search, collection, crc and verdict
  swcrc_deframer #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_deframer (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .rx_bit     (s_tdata[0]),
    .time_ms    (s_tdata[TIME_W:1]),
    .out_busy   (m_tvalid),
    .load       (load),
    .frame_bytes(frame_bytes),
    .frame_info (frame_info)
  );

  // per-byte result stream
  swcrc_emitter #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .frame_bytes(frame_bytes),
    .frame_info (frame_info),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/swcrc_checker.sv -----
`default_nettype none

module swcrc_checker #(
  parameter int FRAME_BYTES = 11
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [swcrc_pkg::M_TDATA_W-1:0]    m_tdata,
  input wire logic                               m_tlast
);
  import swcrc_pkg::*;

  // stalled request stays valid
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result request dropped while stalled");

  // stalled request holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result payload changed while stalled");

  // the final byte carries the last index
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[11:8] == INDEX_W'(FRAME_BYTES - 1))
    else $error("last byte with wrong index");

  // a frame goes out without gaps
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a frame");

  // gap is zero unless the frame is a verified repeat
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13:12] != STAT_VERIFIED |-> m_tdata[49:18] == '0)
    else $error("nonzero gap on an unverified frame");

endmodule

bind sync_word_crc8_frame_receiver swcrc_checker #(
  .FRAME_BYTES(FRAME_BYTES)
) u_swcrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/frame_result_checker.sv -----
module frame_result_checker
  import swcrc_pkg::*;
#(
  parameter int FRAME_BYTES = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIN_W-1:0]     cfg_data,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  // rx_bit [0], time_ms [32:1], zero fill
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  // frame_byte [7:0], byte_index [11:8], frame_status [13:12],
  // channel_code [17:14], verified_gap_ms [49:18], zero fill
  input  wire logic [M_TDATA_W-1:0] m_tdata,
  input  wire logic                 m_tlast,
  output int                        fail_count,
  output int                        pending
);

  // one expected byte of a finished frame
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
    logic               last;
    frame_info_t        info;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];

  // shadow of the receiver state
  logic [WIN_W-1:0]  mask_q;
  logic [WIN_W-1:0]  pattern_q;
  logic [WIN_W-1:0]  window_q;
  logic              searching;
  int                byte_pos;
  int                bit_pos;
  logic [7:0]        crc_q;
  logic [BYTE_W-1:0] frame_buf [FRAME_BYTES];
  logic              prev_valid;
  logic [CHAN_W-1:0] prev_chan;
  logic [BYTE_W-1:0] prev_last;
  logic [TIME_W-1:0] verify_time;

  // crc-8 fed one data bit at a time, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic void clear_state();
    mask_q = SYNC_MASK_RESET;
    pattern_q = SYNC_PATTERN_RESET;
    window_q = '0;
    searching = 1'b1;
    byte_pos = 0;
    bit_pos = 0;
    crc_q = 8'h00;
    prev_valid = 1'b0;
    prev_chan = '0;
    prev_last = '0;
    verify_time = '0;
  endfunction

  function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // frame end: status, verify bookkeeping and one expectation per byte
  function automatic void finish_frame(input logic [TIME_W-1:0] now);
    frame_info_t info;
    frame_byte_t r;
    logic [BYTE_W-1:0] last_byte;
    info.channel = frame_buf[1][7:4];
    info.gap = '0;
    last_byte = frame_buf[FRAME_BYTES-1];
    if (crc_q == 8'h00) begin
      if (prev_valid && info.channel == prev_chan && last_byte == prev_last) begin
        info.status = STAT_VERIFIED;
        info.gap = now - verify_time;
        verify_time = now;
        prev_valid = 1'b0;
      end else begin
        info.status = STAT_GOOD;
        prev_valid = 1'b1;
      end
      prev_last = last_byte;
      prev_chan = info.channel;
    end else begin
      info.status = STAT_CRC_ERR;
      prev_valid = 1'b0;
    end
    for (int k = 0; k < FRAME_BYTES; k++) begin
      r.data = frame_buf[k];
      r.index = k[INDEX_W-1:0];
      r.last = (k == FRAME_BYTES - 1);
      r.info = info;
      expected_bytes.push_back(r);
    end
    searching = 1'b1;
    byte_pos = 0;
    bit_pos = 0;
    window_q = '0;
  endfunction

  // one received bit through the hunt or the collection
  function automatic void predict_bit(input logic rx, input logic [TIME_W-1:0] now);
    logic [WIN_W+1:0] full;
    if (searching) begin
      window_q = {window_q[WIN_W-2:0], rx};
      if ((window_q & mask_q) == pattern_q) begin
        full = {FIX_BITS, window_q};
        frame_buf[0] = full[19:12];
        frame_buf[1] = full[11:4];
        frame_buf[2] = {4'h0, full[3:0]};
        byte_pos = 2;
        bit_pos = 4;
        crc_q = crc8_step(8'h00, frame_buf[1]);
        window_q = '0;
        searching = 1'b0;
      end
    end else begin
      frame_buf[byte_pos] = {frame_buf[byte_pos][6:0], rx};
      bit_pos++;
      if (bit_pos == 8) begin
        crc_q = crc8_step(crc_q, frame_buf[byte_pos]);
        bit_pos = 0;
        byte_pos++;
        if (byte_pos == FRAME_BYTES) begin
          finish_frame(now);
        end
      end
    end
  endfunction

  // watch config, result and request channels
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      clear_state();
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SYNC_MASK) begin
          mask_q = cfg_data;
        end else if (cfg_index == REG_SYNC_PATTERN) begin
          pattern_q = cfg_data;
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("result byte %0h with no frame expected", m_tdata[7:0]);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("frame_byte", TIME_W'(want.data), TIME_W'(m_tdata[7:0]));
          check_field("byte_index", TIME_W'(want.index), TIME_W'(m_tdata[11:8]));
          check_field("last", TIME_W'(want.last), TIME_W'(m_tlast));
          check_field("frame_status", TIME_W'(want.info.status), TIME_W'(m_tdata[13:12]));
          check_field("channel_code", TIME_W'(want.info.channel), TIME_W'(m_tdata[17:14]));
          check_field("verified_gap_ms", want.info.gap, m_tdata[49:18]);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_bit(s_tdata[0], s_tdata[32:1]);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ----- tb/sync_word_crc8_frame_receiver_tb.sv -----
module sync_word_crc8_frame_receiver_tb;
  import swcrc_pkg::*;

  localparam int FRAME_BYTES = 11;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [1:0] {FRAME_FRESH, FRAME_REPEAT, FRAME_CORRUPT} frame_kind_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SYNC_MASK;
  logic [WIN_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  int                   fail_count;
  int                   pending;

  int                   tx_idle_pct = 20;
  int                   rx_idle_pct = 61;
  int                   cycle_count = 0;
  logic [TIME_W-1:0]    ms_clock;
  logic [WIN_W-1:0]     cur_mask = SYNC_MASK_RESET;
  logic [WIN_W-1:0]     cur_pattern = SYNC_PATTERN_RESET;
  logic [WIN_W-1:0]     sync_word;
  logic [BYTE_W-1:0]    frame_bytes [FRAME_BYTES];
  logic                 have_good = 1'b0;

  sync_word_crc8_frame_receiver #(.FRAME_BYTES(FRAME_BYTES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  frame_result_checker #(.FRAME_BYTES(FRAME_BYTES)) result_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // crc over bytes 1 to the one before last, byte-wise form
  function automatic logic [7:0] body_crc();
    logic [7:0] c;
    c = 8'h00;
    for (int k = 1; k < FRAME_BYTES - 1; k++) begin
      c = c ^ frame_bytes[k];
      repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // one request with random sender gaps
  task automatic push_item(input logic rx, input logic [TIME_W-1:0] stamp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_TDATA_W - TIME_W - 1){1'b0}}, stamp, rx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // millisecond time mostly creeps forward, sometimes jumps anywhere
  task automatic push_bit(input logic rx);
    if ($urandom_range(0, 15) == 0) begin
      ms_clock = $urandom();
    end else begin
      ms_clock = ms_clock + $urandom_range(0, 3);
    end
    push_item(rx, ms_clock);
  endtask

  // msb first
  task automatic push_bits(input logic [31:0] value, input int count);
    for (int i = count - 1; i >= 0; i--) begin
      push_bit(value[i]);
    end
  endtask

  // hold the sender until every frame byte is out
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SYNC_MASK) begin
      cur_mask = value;
    end else begin
      cur_pattern = value;
    end
    have_good = 1'b0;
  endtask

  // sync word plus body; a repeat resends the last good frame as is
  task automatic send_frame(input frame_kind_t kind);
    logic [WIN_W-1:0] noise;
    if (kind != FRAME_REPEAT || !have_good) begin
      noise = WIN_W'($urandom());
      sync_word = (noise & ~cur_mask) | (cur_pattern & cur_mask);
      frame_bytes[1] = sync_word[11:4];
      frame_bytes[2] = {sync_word[3:0], 4'($urandom_range(0, 15))};
      for (int k = 3; k < FRAME_BYTES - 1; k++) begin
        case ($urandom_range(0, 7))
          0: frame_bytes[k] = 8'h00;
          1: frame_bytes[k] = 8'hFF;
          default: frame_bytes[k] = 8'($urandom());
        endcase
      end
      frame_bytes[FRAME_BYTES-1] = body_crc();
      if (kind == FRAME_CORRUPT) begin
        frame_bytes[FRAME_BYTES-1] = frame_bytes[FRAME_BYTES-1] ^ (8'h01 << $urandom_range(0, 7));
      end
      have_good = (kind != FRAME_CORRUPT);
    end
    push_bits(32'(sync_word), WIN_W);
    push_bits(32'(frame_bytes[2][3:0]), 4);
    for (int k = 3; k < FRAME_BYTES; k++) begin
      push_bits(32'(frame_bytes[k]), 8);
    end
  endtask

  // stimulus and verdict
  initial begin
    ms_clock = $urandom();
    sync_word = cur_pattern;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // time extremes and noise while hunting, then a good frame
    push_item(1'b1, '0);
    push_item(1'b0, '1);
    push_item(1'b0, '0);
    push_item(1'b1, '1);
    repeat (12) push_bit(1'($urandom_range(0, 1)));
    send_frame(FRAME_FRESH);

    // sender slower than receiver, verified repeat
    wait_drain();
    tx_idle_pct = 61;
    rx_idle_pct = 20;
    send_frame(FRAME_REPEAT);

    // random sync, no idling, crc error
    wait_drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_SYNC_MASK, WIN_W'($urandom()));
    write_reg(REG_SYNC_PATTERN, WIN_W'($urandom()) & cur_mask);
    send_frame(FRAME_CORRUPT);

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * FRAME_BYTES + SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sync_word_crc8_frame_receiver.f -----
rtl/swcrc_pkg.sv
rtl/swcrc_deframer.sv
rtl/swcrc_emitter.sv
rtl/sync_word_crc8_frame_receiver.sv
rtl/swcrc_checker.sv
tb/frame_result_checker.sv
tb/sync_word_crc8_frame_receiver_tb.sv
